FILE: hw/rtl/bts_pkg.sv
package bts_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W    = 20;
  localparam int CFG_W      = 7;
  localparam int POS_W      = 6;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int TEXEL_W    = CHAN_W * NUM_CHAN;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int NUM_TAPS   = 4;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int WGT_W      = FRAC_BITS + 1;
  localparam int XP_W       = CHAN_W + WGT_W;
  localparam int XL_W       = CHAN_W + FRAC_BITS;
  localparam int YP_W       = XL_W + WGT_W;
  localparam int YL_W       = CHAN_W + 2 * FRAC_BITS;
  localparam int ROUND_HALF = 1 << (2 * FRAC_BITS - 1);
  localparam int CMP_W      = ((CFG_W + FRAC_BITS > COORD_W) ? CFG_W + FRAC_BITS : COORD_W) + 1;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 1'd1;
  localparam logic [CFG_W-1:0]     SIZE_RESET        = 7'd64;

  localparam int TAP00 = 0;
  localparam int TAP10 = 1;
  localparam int TAP01 = 2;
  localparam int TAP11 = 3;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [POS_W-1:0]          texel_col;
    logic [POS_W-1:0]          texel_row;
    logic [CHAN_W-1:0]         texel_red;
    logic [CHAN_W-1:0]         texel_green;
    logic [CHAN_W-1:0]         texel_blue;
    logic [CHAN_W-1:0]         texel_alpha;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
  } result_t;

  typedef struct packed {
    cmd_t                                  op;
    logic [NUM_BANKS-1:0]                  bank_we;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]     addr;
    logic [TEXEL_W-1:0]                    wdata;
    logic [NUM_TAPS-1:0][BANK_SEL_W-1:0]   tap_bank;
    logic [FRAC_BITS-1:0]                  fu;
    logic [FRAC_BITS-1:0]                  fv;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0]     i0;
    logic [CFG_W-1:0]     i1;
    logic [FRAC_BITS-1:0] frac;
  } split_t;

endpackage

FILE: hw/rtl/bilinear_texel_sampler_top.sv
// path: a sample passes a queue slot, the bank read into stage s1, stages s2 and s3 and
// the output register; a write takes one queue slot and gives no result
// throughput: one item per cycle while not stalled, set by one access per cycle to each of four texel banks
// a stalled output holds the back end while the front keeps filling a 4-entry queue
// reset: sizes in use return to 64, queue and pipeline empty; the texel store is not
// cleared and holds undefined data until written
module bilinear_texel_sampler_top import bts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] width_in_use;
  logic [CFG_W-1:0] height_in_use;
  logic             push;
  entry_t           push_entry;
  logic             q_full;
  logic             q_valid;
  entry_t           q_head;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= SIZE_RESET;
      height_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_IN_USE:  width_in_use  <= cfg_data;
        REG_HEIGHT_IN_USE: height_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  bts_front u_front (
    .item_valid   (item_valid),
    .item         (item),
    .item_stall   (item_stall),
    .width_in_use (width_in_use),
    .height_in_use(height_in_use),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  bts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .valid     (q_valid)
  );

  bts_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid && !q_valid)
    else $error("pipeline not empty after reset");

  a_pop_legal: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && !(result_valid && result_stall))
    else $error("queue popped while empty or back end stalled");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push into full queue");

  a_bank_we: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> $onehot0(q_head.bank_we) &&
                !(q_head.op == CMD_SAMPLE && q_head.bank_we != '0))
    else $error("bad bank write enables at queue head");

endmodule

FILE: hw/rtl/bts_ram.sv
module bts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hw/rtl/bts_queue.sv
module bts_queue import bts_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;

  assign wr_ptr_next = (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head  = slots[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));

endmodule

FILE: hw/rtl/bts_front.sv
module bts_front import bts_pkg::*; (
  input  logic             item_valid,
  input  item_t            item,
  output logic             item_stall,
  input  logic [CFG_W-1:0] width_in_use,
  input  logic [CFG_W-1:0] height_in_use,
  input  logic             q_full,
  output logic             push,
  output entry_t           push_entry
);

  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r, input int maxv);
    logic [CFG_W-1:0] e;
    if (r == '0) begin
      e = CFG_W'(1);
    end else if (int'(r) > maxv) begin
      e = CFG_W'(maxv);
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic split_t split_coord(input logic signed [COORD_W-1:0] c,
                                         input logic [CFG_W-1:0] size);
    logic signed [CMP_W-1:0] cx;
    logic signed [CMP_W-1:0] hi;
    logic signed [CMP_W-1:0] cl;
    split_t                  s;
    cx = {{(CMP_W - COORD_W){c[COORD_W-1]}}, c};
    hi = signed'({{(CMP_W - CFG_W - FRAC_BITS){1'b0}}, size - 1'b1, {FRAC_BITS{1'b0}}});
    if (cx[CMP_W-1]) begin
      cl = '0;
    end else if (cx > hi) begin
      cl = hi;
    end else begin
      cl = cx;
    end
    s.i0   = cl[FRAC_BITS +: CFG_W];
    s.frac = cl[FRAC_BITS-1:0];
    s.i1   = (s.i0 == size - 1'b1) ? s.i0 : s.i0 + 1'b1;
    return s;
  endfunction

  function automatic logic [BANK_AW-1:0] bank_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
    return BANK_AW'(int'(row >> 1) * HALF_W + int'(col >> 1));
  endfunction

  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  split_t           sx;
  split_t           sy;
  logic [COL_W-1:0] u0;
  logic [COL_W-1:0] u1;
  logic [ROW_W-1:0] v0;
  logic [ROW_W-1:0] v1;
  logic [COL_W-1:0] col_sel [2];
  logic [ROW_W-1:0] row_sel [2];
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic             wr_in_range;

  assign w_eff = eff_size(width_in_use, MAX_WIDTH);
  assign h_eff = eff_size(height_in_use, MAX_HEIGHT);
  assign sx    = split_coord(item.coord_x, w_eff);
  assign sy    = split_coord(item.coord_y, h_eff);
  assign u0    = COL_W'(sx.i0);
  assign u1    = COL_W'(sx.i1);
  assign v0    = ROW_W'(sy.i0);
  assign v1    = ROW_W'(sy.i1);

  // each bank parity takes whichever neighbor has that parity
  assign col_sel[0] = u0[0] ? u1 : u0;
  assign col_sel[1] = u0[0] ? u0 : u1;
  assign row_sel[0] = v0[0] ? v1 : v0;
  assign row_sel[1] = v0[0] ? v0 : v1;

  assign wr_col      = COL_W'(item.texel_col);
  assign wr_row      = ROW_W'(item.texel_row);
  assign wr_in_range = (int'(item.texel_col) < MAX_WIDTH) && (int'(item.texel_row) < MAX_HEIGHT);

  always_comb begin
    push_entry = '0;
    if (item.cmd == CMD_WRITE) begin
      push_entry.op = CMD_WRITE;
      for (int b = 0; b < NUM_BANKS; b++) begin
        push_entry.addr[b] = bank_addr(wr_col, wr_row);
      end
      if (wr_in_range) begin
        push_entry.bank_we = NUM_BANKS'(1) << {wr_row[0], wr_col[0]};
      end
      push_entry.wdata = {item.texel_alpha, item.texel_blue, item.texel_green, item.texel_red};
    end else begin
      push_entry.op              = CMD_SAMPLE;
      push_entry.addr[0]         = bank_addr(col_sel[0], row_sel[0]);
      push_entry.addr[1]         = bank_addr(col_sel[1], row_sel[0]);
      push_entry.addr[2]         = bank_addr(col_sel[0], row_sel[1]);
      push_entry.addr[3]         = bank_addr(col_sel[1], row_sel[1]);
      push_entry.tap_bank[TAP00] = {v0[0], u0[0]};
      push_entry.tap_bank[TAP10] = {v0[0], u1[0]};
      push_entry.tap_bank[TAP01] = {v1[0], u0[0]};
      push_entry.tap_bank[TAP11] = {v1[0], u1[0]};
      push_entry.fu              = sx.frac;
      push_entry.fv              = sy.frac;
    end
  end

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

endmodule

FILE: hw/rtl/bts_back.sv
module bts_back import bts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  entry_t  q_head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic                                advance;
  logic                                rd_en;
  logic [NUM_BANKS-1:0][TEXEL_W-1:0]   bank_rdata;

  logic                                s1_valid;
  logic [NUM_TAPS-1:0][BANK_SEL_W-1:0] s1_tap_bank;
  logic [FRAC_BITS-1:0]                s1_fu;
  logic [FRAC_BITS-1:0]                s1_fv;
  logic [NUM_TAPS-1:0][TEXEL_W-1:0]    taps;
  logic [WGT_W-1:0]                    wx0;
  logic [WGT_W-1:0]                    wx1;
  logic [NUM_CHAN-1:0][XL_W-1:0]       top_x;
  logic [NUM_CHAN-1:0][XL_W-1:0]       bot_x;

  logic                                s2_valid;
  logic [NUM_CHAN-1:0][XL_W-1:0]       s2_top;
  logic [NUM_CHAN-1:0][XL_W-1:0]       s2_bot;
  logic [FRAC_BITS-1:0]                s2_fv;
  logic [WGT_W-1:0]                    wy0;
  logic [WGT_W-1:0]                    wy1;
  logic [NUM_CHAN-1:0][YL_W-1:0]       sum_y;

  logic                                s3_valid;
  logic [NUM_CHAN-1:0][YL_W-1:0]       s3_sum;
  logic [NUM_CHAN-1:0][YL_W-1:0]       rounded;
  logic [NUM_CHAN-1:0][CHAN_W-1:0]     chan_out;

  // whole back end moves together whenever the output register can take a transfer
  assign advance = !result_valid || !result_stall;
  assign pop     = advance && q_valid;
  assign rd_en   = pop && (q_head.op == CMD_SAMPLE);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    bts_ram #(
      .WIDTH(TEXEL_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (pop && q_head.bank_we[b]),
      .re   (rd_en),
      .addr (q_head.addr[b]),
      .wdata(q_head.wdata),
      .rdata(bank_rdata[b])
    );
  end

  // x lerp on the four taps
  always_comb begin
    wx0 = WGT_W'(ONE) - WGT_W'(s1_fu);
    wx1 = WGT_W'(s1_fu);
    for (int t = 0; t < NUM_TAPS; t++) begin
      taps[t] = bank_rdata[s1_tap_bank[t]];
    end
    for (int k = 0; k < NUM_CHAN; k++) begin
      top_x[k] = XL_W'(XP_W'(taps[TAP00][k*CHAN_W +: CHAN_W]) * XP_W'(wx0)
                     + XP_W'(taps[TAP10][k*CHAN_W +: CHAN_W]) * XP_W'(wx1));
      bot_x[k] = XL_W'(XP_W'(taps[TAP01][k*CHAN_W +: CHAN_W]) * XP_W'(wx0)
                     + XP_W'(taps[TAP11][k*CHAN_W +: CHAN_W]) * XP_W'(wx1));
    end
  end

  // y lerp
  always_comb begin
    wy0 = WGT_W'(ONE) - WGT_W'(s2_fv);
    wy1 = WGT_W'(s2_fv);
    for (int k = 0; k < NUM_CHAN; k++) begin
      sum_y[k] = YL_W'(YP_W'(s2_top[k]) * YP_W'(wy0) + YP_W'(s2_bot[k]) * YP_W'(wy1));
    end
  end

  // round to nearest, halves up
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      rounded[k]  = s3_sum[k] + YL_W'(ROUND_HALF);
      chan_out[k] = rounded[k][2*FRAC_BITS +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= rd_en;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tap_bank      <= q_head.tap_bank;
      s1_fu            <= q_head.fu;
      s1_fv            <= q_head.fv;
      s2_top           <= top_x;
      s2_bot           <= bot_x;
      s2_fv            <= s1_fv;
      s3_sum           <= sum_y;
      result.out_red   <= chan_out[0];
      result.out_green <= chan_out[1];
      result.out_blue  <= chan_out[2];
      result.out_alpha <= chan_out[3];
    end
  end

endmodule
